/* rtl/core/wsc_pkg.sv */
// ---------------------------------------------------------------------------
// wsc_pkg: shared types and constants for the waveshaping compander
// Holds the beat structs, operation codes and the pipeline sizes.
// ---------------------------------------------------------------------------
`default_nettype none
package wsc_pkg;

  localparam int unsigned TablePointsDef = 64;
  localparam int unsigned SqrtSteps      = 24;  // result bits of the root
  localparam int unsigned DivSteps       = 17;  // quotient bits, 0..131071 covered

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_PROCESS = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [5:0]  table_index;
    logic [15:0] table_value;
    logic signed [15:0] in_re;
    logic signed [15:0] in_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               clipped;
  } out_beat_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic        wr;      // table write, travels in order with the samples
    logic [5:0]  wr_idx;
    logic [15:0] wr_val;
    logic        zero;
    logic        neg_re;
    logic        neg_im;
    logic [15:0] mag_re;
    logic [15:0] mag_im;
    logic [33:0] rad;  // (re^2 + im^2), shifted by 16 inside the root unit
  } work_t;

endpackage
`default_nettype wire

/* rtl/core/waveshaping_compander.sv */
// Throughput: one beat per cycle, writes and samples alike, while the output
// is not stalled and the table load after reset is done; writes give no result.
// Table writes travel through the pipeline in order with the samples.
// Reset empties all stages at once, then loads the table with a linear ramp,
// one entry a cycle; up to three beats are taken meanwhile.
// ---------------------------------------------------------------------------
// waveshaping_compander: top level
// Front stage, work queue and shaping pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module waveshaping_compander #(
  parameter int unsigned TablePoints = wsc_pkg::TablePointsDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire wsc_pkg::in_beat_t in_data_i,
  output logic                   out_valid,
  input  wire                    out_stall,
  output wsc_pkg::out_beat_t     out_data_o
);
  logic fv, fs, bv, bs;
  wsc_pkg::work_t fd, bd;

  wsc_front u_front (.clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .q_valid_o(fv), .q_stall_i(fs), .q_data_o(fd));

  wsc_fifo u_fifo (.clk_i, .rst_ni, .w_valid_i(fv), .w_stall_o(fs), .w_data_i(fd),
    .r_valid_o(bv), .r_stall_i(bs), .r_data_o(bd));

  wsc_back #(.TablePoints(TablePoints)) u_back (.clk_i, .rst_ni,
    .q_valid_i(bv), .q_stall_o(bs), .q_data_i(bd),
    .out_valid, .out_stall, .out_data_o);
endmodule
`default_nettype wire

/* rtl/core/wsc_front.sv */
// ---------------------------------------------------------------------------
// wsc_front: input stage
// Registers each beat, squares the parts and forms the radicand.
// ---------------------------------------------------------------------------
`default_nettype none
module wsc_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire wsc_pkg::in_beat_t in_data_i,
  output logic                   q_valid_o,
  input  wire                    q_stall_i,
  output wsc_pkg::work_t         q_data_o
);
  logic          valid_q;
  wsc_pkg::work_t data_q, data_d;
  logic          take;
  logic [15:0]   mr, mi;

  assign in_stall = valid_q && q_stall_i;
  assign take     = in_valid && !in_stall;

  // classify a beat; writes keep their place among the samples
  always_comb begin
    mr = in_data_i.in_re[15] ? 16'(-in_data_i.in_re) : 16'(in_data_i.in_re);
    mi = in_data_i.in_im[15] ? 16'(-in_data_i.in_im) : 16'(in_data_i.in_im);
    data_d.wr     = (in_data_i.op == wsc_pkg::OP_WRITE);
    data_d.wr_idx = in_data_i.table_index;
    data_d.wr_val = in_data_i.table_value;
    data_d.neg_re = in_data_i.in_re[15];
    data_d.neg_im = in_data_i.in_im[15];
    data_d.mag_re = mr;
    data_d.mag_im = mi;
    data_d.rad    = 34'(32'(mr) * 32'(mr)) + 34'(32'(mi) * 32'(mi));
    data_d.zero   = (mr == 16'd0) && (mi == 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_data_o  = data_q;
endmodule
`default_nettype wire

/* rtl/core/wsc_fifo.sv */
// ---------------------------------------------------------------------------
// wsc_fifo: two-entry work queue
// Decouples the front stage from the back pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module wsc_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  w_valid_i,
  output logic                 w_stall_o,
  input  wire wsc_pkg::work_t  w_data_i,
  output logic                 r_valid_o,
  input  wire                  r_stall_i,
  output wsc_pkg::work_t       r_data_o
);
  wsc_pkg::work_t mem_q [2];
  logic rp_q, wp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign w_stall_o = (cnt_q == 2'd2);
  assign r_valid_o = (cnt_q != 2'd0);
  assign r_data_o  = mem_q[rp_q];
  assign push = w_valid_i && !w_stall_o;
  assign pop  = r_valid_o && !r_stall_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= w_data_i;
  end
endmodule
`default_nettype wire

/* rtl/core/wsc_back.sv */
// ---------------------------------------------------------------------------
// wsc_back: shaping pipeline
// Pipelined root, table interpolation, pipelined divide and saturation,
// with the generic registered-read RAM that holds the shaping table.
// ---------------------------------------------------------------------------
`default_nettype none
module wsc_back #(
  parameter int unsigned TablePoints = wsc_pkg::TablePointsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_valid_i,
  output logic                 q_stall_o,
  input  wire wsc_pkg::work_t  q_data_i,
  output logic                 out_valid,
  input  wire                  out_stall,
  output wsc_pkg::out_beat_t   out_data_o
);
  localparam int unsigned IW = (TablePoints > 1) ? $clog2(TablePoints) : 1;
  localparam int unsigned SQ = wsc_pkg::SqrtSteps;
  localparam int unsigned DQ = wsc_pkg::DivSteps;
  localparam int unsigned NS = SQ + 3 + DQ + 1;  // total stages

  // reset ramp stepping: entry i = (span + i*65536) / (2*span), kept as quotient and rest
  localparam int unsigned RampSpan  = (TablePoints > 1) ? TablePoints - 1 : 1;
  localparam int unsigned RampDen   = 2 * RampSpan;
  localparam int unsigned RampQStep = 65536 / RampDen;
  localparam int unsigned RampRStep = 65536 % RampDen;

  // pipeline advances only when the output side is free
  logic adv;
  logic q_take;
  logic [NS-1:0] v_q;
  logic [SQ-1:0] w_q;
  logic init_q;
  assign adv       = !(out_valid && out_stall);
  assign q_stall_o = !adv || init_q;
  assign q_take    = q_valid_i && !q_stall_o;

  // table load after reset, one ramp entry a cycle
  logic [IW-1:0] init_idx_q;
  logic [15:0]   ramp_q, ramp_d;
  logic [11:0]   ramp_rem_q, ramp_rem_d;
  logic [11:0]   rem_sum;
  always_comb begin
    rem_sum = ramp_rem_q + 12'(RampRStep);
    if (rem_sum >= 12'(RampDen)) begin
      ramp_d     = ramp_q + 16'(RampQStep) + 16'd1;
      ramp_rem_d = rem_sum - 12'(RampDen);
    end else begin
      ramp_d     = ramp_q + 16'(RampQStep);
      ramp_rem_d = rem_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_idx_q <= '0;
      ramp_q     <= '0;
      ramp_rem_q <= 12'(RampSpan);
    end else if (init_q) begin
      init_idx_q <= init_idx_q + IW'(1);
      ramp_q     <= ramp_d;
      ramp_rem_q <= ramp_rem_d;
      if (init_idx_q == IW'(TablePoints - 1)) init_q <= 1'b0;
    end
  end

  // valid chains: samples through the whole pipe, writes up to the table stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      w_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], q_take && !q_data_i.wr};
      w_q <= {w_q[SQ-2:0], q_take && q_data_i.wr};
    end
  end

  // ---- square root: one result bit a stage, radicand rad<<16 (48 bits used)
  typedef struct packed {
    logic        zero, neg_re, neg_im;
    logic [15:0] mag_re, mag_im;
  } side_t;
  side_t       s_sd [SQ+1];
  logic [49:0] s_rem [SQ+1];
  logic [23:0] s_res [SQ+1];
  logic [49:0] s_rad [SQ+1];
  logic [5:0]  s_wi [SQ+1];
  logic [15:0] s_wv [SQ+1];
  assign s_sd[0]  = '{q_data_i.zero, q_data_i.neg_re, q_data_i.neg_im,
                      q_data_i.mag_re, q_data_i.mag_im};
  assign s_rem[0] = '0;
  assign s_res[0] = '0;
  assign s_rad[0] = {q_data_i.rad, 16'd0};
  assign s_wi[0]  = q_data_i.wr_idx;
  assign s_wv[0]  = q_data_i.wr_val;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [49:0] rem_n, trial;
    logic [23:0] res_n;
    always_comb begin
      rem_n = {s_rem[k][47:0], s_rad[k][47-2*k -: 2]};
      trial = 50'({s_res[k], 2'b01});
      if (rem_n >= trial) begin
        rem_n = rem_n - trial;
        res_n = {s_res[k][22:0], 1'b1};
      end else begin
        res_n = {s_res[k][22:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_sd[k+1] <= s_sd[k]; s_rem[k+1] <= rem_n;
        s_res[k+1] <= res_n; s_rad[k+1] <= s_rad[k];
        s_wi[k+1] <= s_wi[k]; s_wv[k+1] <= s_wv[k];
      end
    end
  end

  // ---- index / fraction, table read
  logic [33:0] pos;
  logic [IW-1:0] ia, ib;
  logic [22:0] fr_d;
  logic past_d;
  side_t t1_sd; logic [23:0] t1_m; logic [22:0] t1_fr; logic [15:0] t1_a, t1_b;
  always_comb begin
    pos    = 34'(s_res[SQ]) * 34'(TablePoints);
    fr_d   = pos[22:0];
    past_d = (pos[33:23] >= 11'(TablePoints - 1));
    ia     = past_d ? IW'(TablePoints - 1) : IW'(pos[33:23]);
    ib     = past_d ? ia : IW'(ia + IW'(1));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_sd <= s_sd[SQ]; t1_m <= s_res[SQ];
      t1_fr <= past_d ? 23'd0 : fr_d;
    end
  end

  // table write port: ramp load after reset, then writes at the table stage
  logic          pipe_wr;
  logic          tw_en;
  logic [IW-1:0] tw_addr;
  logic [15:0]   tw_data;
  assign pipe_wr = adv && w_q[SQ-1] && (32'(s_wi[SQ]) < TablePoints);
  assign tw_en   = init_q || pipe_wr;
  assign tw_addr = init_q ? init_idx_q : IW'(s_wi[SQ]);
  assign tw_data = init_q ? ramp_q : s_wv[SQ];

  // two copies of the table give both interpolation points in the same cycle
  wsc_ram #(.Width(16), .Depth(TablePoints)) u_tbl_a (
    .clk_i, .we_i(tw_en), .waddr_i(tw_addr), .wdata_i(tw_data),
    .re_i(adv), .raddr_i(ia), .rdata_o(t1_a));

  wsc_ram #(.Width(16), .Depth(TablePoints)) u_tbl_b (
    .clk_i, .we_i(tw_en), .waddr_i(tw_addr), .wdata_i(tw_data),
    .re_i(adv), .raddr_i(ib), .rdata_o(t1_b));

  // ---- interpolate: y38 = a<<23 + fr*(b-a)
  side_t t2_sd; logic [23:0] t2_m; logic [39:0] t2_y;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_sd <= t1_sd; t2_m <= t1_m;
      t2_y  <= 40'($signed({1'b0, t1_a, 23'd0})
             + $signed({1'b0, t1_fr}) * ($signed({1'b0, t1_b}) - $signed({1'b0, t1_a})));
    end
  end

  // ---- numerators mag*y38 + den/2, den = m<<15
  side_t t3_sd; logic [38:0] t3_den; logic [55:0] t3_nr, t3_ni;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_sd  <= t2_sd;
      t3_den <= {t2_m, 15'd0};
      t3_nr  <= 56'(t2_sd.mag_re * t2_y[38:0]) + 56'({t2_m, 14'd0});
      t3_ni  <= 56'(t2_sd.mag_im * t2_y[38:0]) + 56'({t2_m, 14'd0});
    end
  end

  // ---- restoring divide, one quotient bit a stage, both parts in parallel
  side_t       d_sd  [DQ+1];
  logic [38:0] d_den [DQ+1];
  logic [55:0] d_rr  [DQ+1], d_ri [DQ+1];
  logic [DQ-1:0] d_qr [DQ+1], d_qi [DQ+1];
  assign d_sd[0] = t3_sd; assign d_den[0] = t3_den;
  assign d_rr[0] = t3_nr; assign d_ri[0] = t3_ni;
  assign d_qr[0] = '0;    assign d_qi[0] = '0;
  for (genvar k = 0; k < DQ; k++) begin : g_div
    localparam int unsigned SH = DQ - 1 - k;
    logic [55+DQ:0] dsh;
    logic [55:0] rr_n, ri_n;
    logic br, bi;
    always_comb begin
      dsh  = (DQ+56)'(d_den[k]) << SH;
      br   = ((DQ+56)'(d_rr[k]) >= dsh);
      bi   = ((DQ+56)'(d_ri[k]) >= dsh);
      rr_n = br ? 56'((DQ+56)'(d_rr[k]) - dsh) : d_rr[k];
      ri_n = bi ? 56'((DQ+56)'(d_ri[k]) - dsh) : d_ri[k];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_sd[k+1] <= d_sd[k]; d_den[k+1] <= d_den[k];
        d_rr[k+1] <= rr_n; d_ri[k+1] <= ri_n;
        d_qr[k+1] <= {d_qr[k][DQ-2:0], br};
        d_qi[k+1] <= {d_qi[k][DQ-2:0], bi};
      end
    end
  end

  // ---- saturate and sign
  function automatic logic [16:0] sat(input logic [DQ-1:0] q, input logic neg);
    logic [16:0] r;
    if (neg) begin
      if (q > DQ'(32768)) r = {1'b1, 16'h8000};
      else r = {1'b0, 16'(-q[15:0])};
      if (q == DQ'(32768)) r = {1'b0, 16'h8000};
    end else begin
      if (q > DQ'(32767)) r = {1'b1, 16'h7fff};
      else r = {1'b0, q[15:0]};
    end
    return r;
  endfunction

  logic [16:0] fr_r, fr_i;
  assign fr_r = sat(d_qr[DQ], d_sd[DQ].neg_re);
  assign fr_i = sat(d_qi[DQ], d_sd[DQ].neg_im);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_sd[DQ].zero) begin
        out_data_o <= '0;
      end else begin
        out_data_o.out_re  <= fr_r[15:0];
        out_data_o.out_im  <= fr_i[15:0];
        out_data_o.clipped <= fr_r[16] | fr_i[16];
      end
    end
  end

  assign out_valid = v_q[NS-1];
endmodule

// generic single-port-write RAM with registered read
module wsc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = wsc_pkg::TablePointsDef
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read data held while the reader stalls
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the waveshaping compander
// Drives table writes and complex samples with random idling and stalls,
// predicts each result in a scoreboard and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import wsc_pkg::*;

  localparam int unsigned NPoints = TablePointsDef;
  localparam int unsigned Latency = 47;

  // companding predictor and queue of pending results
  class compand_board;
    logic [15:0] shape_tbl [NPoints];
    out_beat_t   pending_q [$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < NPoints; i++) shape_tbl[i] = ramp_value(i, NPoints);
    endfunction

    // reset ramp entry: round(i*32768/(n-1)), halves up
    static function automatic logic [15:0] ramp_value(input int unsigned i,
        input int unsigned n);
      longint unsigned span, v;
      span = (n > 1) ? longint'(n - 1) : 64'd1;
      v = (longint'(i) * 65536 + span) / (2 * span);
      if (v > 65535) v = 65535;
      return v[15:0];
    endfunction

    static function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else res >>= 1;
        bit_w >>= 2;
      end
      return res;
    endfunction

    static function automatic logic [15:0] shape_part(input longint part,
        input logic [63:0] y38, input logic [63:0] m23, inout logic clip);
      logic [127:0] mag, den, q;
      mag = (part < 0) ? -part : part;
      den = m23 << 15;
      q = (mag * y38 + den / 2) / den;
      if (part < 0) begin
        if (q > 32768) begin clip = 1; q = 32768; end
        return -q[15:0];
      end
      if (q > 32767) begin clip = 1; q = 32767; end
      return q[15:0];
    endfunction

    // note an accepted input beat
    function void note_input(input in_beat_t b);
      longint re, im, a, d;
      logic [63:0] sum, m23, p, idx, frac, y38;
      out_beat_t r;
      if (op_e'(b.op) == OP_WRITE) begin
        if (b.table_index < NPoints) shape_tbl[b.table_index] = b.table_value;
        return;
      end
      re = b.in_re;
      im = b.in_im;
      sum = re * re + im * im;
      r = '0;
      if (sum != 0) begin
        m23 = root64(sum << 16);
        p = m23 * NPoints;
        idx = p >> 23;
        frac = p & ((64'd1 << 23) - 1);
        if (idx < NPoints - 1) begin
          a = shape_tbl[idx];
          d = longint'(shape_tbl[idx + 1]) - a;
          y38 = a * (64'sd1 << 23) + longint'(frac) * d;
        end else y38 = 64'(shape_tbl[NPoints - 1]) << 23;
        r.out_re = shape_part(re, y38, m23, r.clipped);
        r.out_im = shape_part(im, y38, m23, r.clipped);
      end
      pending_q.push_back(r);
    endfunction

    // compare a result beat with the oldest pending one
    function void check_result(input out_beat_t got);
      out_beat_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.out_re !== e.out_re) begin
        $error("out_re expected %0d actual %0d", e.out_re, got.out_re); errors++;
      end
      if (got.out_im !== e.out_im) begin
        $error("out_im expected %0d actual %0d", e.out_im, got.out_im); errors++;
      end
      if (got.clipped !== e.clipped) begin
        $error("clipped expected %0b actual %0b", e.clipped, got.clipped); errors++;
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_beat_t out_data;

  compand_board board = new();
  int  idle_pct = 34;
  int  hold_off = 0;
  bit  stim_done = 0;

  waveshaping_compander i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data_i (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data_o(out_data)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // offer one beat and wait until it is taken
  task automatic send_beat(input in_beat_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
    in_valid <= 1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.note_input(b);
    @(negedge clk_i);
  endtask

  task automatic send_write(input int idx, input int val);
    in_beat_t b;
    b = '0;
    b.op = OP_WRITE;
    b.table_index = 6'(idx);
    b.table_value = 16'(val);
    b.in_re = 16'($urandom);
    b.in_im = 16'($urandom);
    send_beat(b);
  endtask

  task automatic send_sample(input int re, input int im);
    in_beat_t b;
    b = '0;
    b.op = OP_PROCESS;
    b.table_index = 6'($urandom);
    b.table_value = 16'($urandom);
    b.in_re = 16'(re);
    b.in_im = 16'(im);
    send_beat(b);
  endtask

  // random sample, mostly full scale, sometimes tiny
  task automatic send_rand_sample();
    if ($urandom_range(9) == 0)
      send_sample($signed($urandom_range(15)) - 8, $signed($urandom_range(15)) - 8);
    else send_sample($urandom, $urandom);
  endtask

  // receiver side: random stalls plus a single long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall) board.check_result(out_data);

  initial begin
    int n;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: reset ramp, extremes, zero, saturation, writes
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(-32768, 0);
    send_sample(0, -32768);
    send_sample(-32768, -32768);
    send_sample(32767, 32767);
    send_sample(1, 0);
    send_sample(0, -1);
    send_sample(12345, -23456);
    send_write(0, 65535);
    send_write(63, 65535);
    send_write(31, 0);
    send_write(1, 43690);
    send_write(62, 21845);
    send_sample(1, 1);
    send_sample(-32768, 32767);
    send_sample(16384, 0);
    send_sample(-100, 200);
    send_sample(0, 0);
    send_write(63, 0);
    send_sample(32767, -32768);
    send_sample(20000, 20000);

    // random: table loads mixed with sample streams
    for (n = 0; n < 600; n++) begin
      if (n == 150) idle_pct = 0;
      if (n == 250) idle_pct = 34;
      if (n == 300) hold_off = 300;
      if ($urandom_range(9) < 2) send_write($urandom_range(63), $urandom);
      else send_rand_sample();
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
